// ===== hw/rtl/cau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_MUL   = 4'd2;
	localparam logic [3:0] OP_DIV   = 4'd3;
	localparam logic [3:0] OP_RECIP = 4'd4;
	localparam logic [3:0] OP_NEG   = 4'd5;
	localparam logic [3:0] OP_CONJ  = 4'd6;
	localparam logic [3:0] OP_MSQ   = 4'd7;
	localparam logic [3:0] OP_MAG   = 4'd8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// operation classes as seen by the back end
	localparam logic [3:0] CLS_ADD   = 4'd0;
	localparam logic [3:0] CLS_SUB   = 4'd1;
	localparam logic [3:0] CLS_MUL   = 4'd2;
	localparam logic [3:0] CLS_DIV   = 4'd3;
	localparam logic [3:0] CLS_RECIP = 4'd4;
	localparam logic [3:0] CLS_NEG   = 4'd5;
	localparam logic [3:0] CLS_CONJ  = 4'd6;
	localparam logic [3:0] CLS_MSQ   = 4'd7;
	localparam logic [3:0] CLS_MAG   = 4'd8;
	localparam logic [3:0] CLS_NONE  = 4'd9;

	// multiplier operand selects
	localparam logic [1:0] SEL_AR = 2'd0;
	localparam logic [1:0] SEL_AI = 2'd1;
	localparam logic [1:0] SEL_BR = 2'd2;
	localparam logic [1:0] SEL_BI = 2'd3;

	// product destinations
	localparam logic [2:0] DST_RE_ADD = 3'd0;
	localparam logic [2:0] DST_RE_SUB = 3'd1;
	localparam logic [2:0] DST_IM_ADD = 3'd2;
	localparam logic [2:0] DST_IM_SUB = 3'd3;
	localparam logic [2:0] DST_DEN    = 3'd4;

	typedef struct packed {
		logic [3:0]         cls;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} cau_item_t;

	typedef struct packed {
		logic [1:0] xsel;
		logic [1:0] ysel;
		logic [2:0] dest;
		logic       last;
	} cau_mop_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} cau_sat_t;

	localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
	localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

	function automatic cau_sat_t sat32(input logic signed [65:0] v);
		cau_sat_t r;
		if (v > SAT_MAX) begin
			r.val = 32'h7FFF_FFFF;
			r.sat = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = 32'h8000_0000;
			r.sat = 1'b1;
		end else begin
			r.val = v[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	function automatic logic is_simple(input logic [3:0] cls);
		return (cls == CLS_ADD) || (cls == CLS_SUB) || (cls == CLS_NEG) ||
			(cls == CLS_CONJ) || (cls == CLS_NONE);
	endfunction

	// product schedule of the shared multiplier for each class
	function automatic cau_mop_t mul_sched(input logic [3:0] cls, input logic [2:0] step);
		cau_mop_t m;
		m = '{xsel: SEL_AR, ysel: SEL_AR, dest: DST_DEN, last: 1'b1};
		case (cls)
			CLS_MUL: begin
				case (step)
					3'd0: m = '{SEL_AR, SEL_BR, DST_RE_ADD, 1'b0};
					3'd1: m = '{SEL_AI, SEL_BI, DST_RE_SUB, 1'b0};
					3'd2: m = '{SEL_AR, SEL_BI, DST_IM_ADD, 1'b0};
					default: m = '{SEL_AI, SEL_BR, DST_IM_ADD, 1'b1};
				endcase
			end
			CLS_DIV: begin
				case (step)
					3'd0: m = '{SEL_AR, SEL_BR, DST_RE_ADD, 1'b0};
					3'd1: m = '{SEL_AI, SEL_BI, DST_RE_ADD, 1'b0};
					3'd2: m = '{SEL_AI, SEL_BR, DST_IM_ADD, 1'b0};
					3'd3: m = '{SEL_AR, SEL_BI, DST_IM_SUB, 1'b0};
					3'd4: m = '{SEL_BR, SEL_BR, DST_DEN, 1'b0};
					default: m = '{SEL_BI, SEL_BI, DST_DEN, 1'b1};
				endcase
			end
			default: begin
				// squares of a for reciprocal and both magnitudes
				if (step == 3'd0)
					m = '{SEL_AR, SEL_AR, DST_DEN, 1'b0};
				else
					m = '{SEL_AI, SEL_AI, DST_DEN, 1'b1};
			end
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Accepts commands, classifies the opcode and queues them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module cau_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [3:0]         opcode,
	input  wire logic signed [31:0] a_re,
	input  wire logic signed [31:0] a_im,
	input  wire logic signed [31:0] b_re,
	input  wire logic signed [31:0] b_im,
	output logic                    busy,
	input  wire logic               pop,
	output cau_pkg::cau_item_t      head,
	output logic                    empty
);
	import cau_pkg::*;

	cau_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic [3:0] cls;

	always_comb begin
		case (opcode)
			OP_ADD:   cls = CLS_ADD;
			OP_SUB:   cls = CLS_SUB;
			OP_MUL:   cls = CLS_MUL;
			OP_DIV:   cls = CLS_DIV;
			OP_RECIP: cls = CLS_RECIP;
			OP_NEG:   cls = CLS_NEG;
			OP_CONJ:  cls = CLS_CONJ;
			OP_MSQ:   cls = CLS_MSQ;
			OP_MAG:   cls = CLS_MAG;
			default:  cls = CLS_NONE;
		endcase
	end

	assign busy  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign push  = start && !busy;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= '{cls: cls, a_re: a_re, a_im: a_im, b_re: b_re, b_im: b_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cau_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Executes queued transactions: add/sub/neg/conj straight from the queue head, a shared
// 32x32 multiplier, a bit-serial divider pair and a bit-serial square root.
// ----------------------------------------------------------------------------
module cau_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  cau_pkg::cau_item_t head,
	input  wire logic          empty,
	output logic               pop,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic [1:0]         status
);
	import cau_pkg::*;

	localparam int DIV_ITERS  = 64 + FRAC_BITS;
	localparam int SQRT_ITERS = 32;
	localparam int CNT_W      = $clog2(DIV_ITERS + 1);
	localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_DOUT  = 3'd5;
	localparam logic [2:0] S_SQRT  = 3'd6;
	localparam logic [2:0] S_SOUT  = 3'd7;

	logic [2:0]         state_q;
	logic [2:0]         step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pv_q;
	logic               done_q;
	cau_item_t          item_q;
	logic signed [63:0] p_q;
	logic [2:0]         pdest_q;
	logic signed [65:0] acc_re_q, acc_im_q;
	logic [63:0]        den_q;
	logic               neg_re_q, neg_im_q;
	logic [63:0]        dvd_re_q, dvd_im_q;
	logic [63:0]        rem_re_q, rem_im_q;
	logic [33:0]        q_re_q, q_im_q;
	logic               ovf_re_q, ovf_im_q;
	logic [63:0]        sn_q, sr_q, sbit_q;
	logic signed [31:0] res_re_q, res_im_q;
	logic [1:0]         status_q;

	cau_mop_t           mop;
	logic signed [31:0] mx, my;
	logic signed [63:0] prod;
	logic signed [65:0] pext;
	logic [64:0]        t_re, t_im;
	logic               ge_re, ge_im;
	logic [63:0]        st_sum;
	logic               st_ge;
	logic               emit, div0;
	cau_sat_t           sr_re, sr_im;
	logic signed [65:0] v_re, v_im;
	logic [33:0]        qm_re, qm_im;
	logic               last_div, last_sqrt;

	function automatic logic signed [65:0] sx(input logic signed [31:0] x);
		return $signed({{34{x[31]}}, x});
	endfunction

	function automatic logic signed [31:0] opsel(input logic [1:0] s, input cau_item_t it);
		case (s)
			SEL_AR:  return it.a_re;
			SEL_AI:  return it.a_im;
			SEL_BR:  return it.b_re;
			default: return it.b_im;
		endcase
	endfunction

	assign pop       = (state_q == S_IDLE) && !empty;
	assign mop       = mul_sched(item_q.cls, step_q);
	assign mx        = opsel(mop.xsel, item_q);
	assign my        = opsel(mop.ysel, item_q);
	assign prod      = mx * my;
	assign pext      = $signed({{2{p_q[63]}}, p_q});
	assign last_div  = (cnt_q == CNT_W'(DIV_ITERS - 1));
	assign last_sqrt = (cnt_q == CNT_W'(SQRT_ITERS - 1));

	// one restoring step of each divider and of the root
	assign t_re   = {rem_re_q, dvd_re_q[63]};
	assign t_im   = {rem_im_q, dvd_im_q[63]};
	assign ge_re  = (t_re >= {1'b0, den_q});
	assign ge_im  = (t_im >= {1'b0, den_q});
	assign st_sum = sr_q + sbit_q;
	assign st_ge  = (sn_q >= st_sum);

	assign qm_re = ovf_re_q ? '1 : q_re_q;
	assign qm_im = ovf_im_q ? '1 : q_im_q;

	always_comb begin
		emit = 1'b0;
		div0 = 1'b0;
		v_re = '0;
		v_im = '0;
		case (state_q)
			S_IDLE: begin
				emit = pop && is_simple(head.cls);
				case (head.cls)
					CLS_ADD: begin
						v_re = sx(head.a_re) + sx(head.b_re);
						v_im = sx(head.a_im) + sx(head.b_im);
					end
					CLS_SUB: begin
						v_re = sx(head.a_re) - sx(head.b_re);
						v_im = sx(head.a_im) - sx(head.b_im);
					end
					CLS_NEG: begin
						v_re = -sx(head.a_re);
						v_im = -sx(head.a_im);
					end
					CLS_CONJ: begin
						v_re = sx(head.a_re);
						v_im = -sx(head.a_im);
					end
					default: begin
						v_re = '0;
						v_im = '0;
					end
				endcase
			end
			S_FIN: begin
				case (item_q.cls)
					CLS_MUL: begin
						emit = 1'b1;
						v_re = (acc_re_q + RND_HALF) >>> FRAC_BITS;
						v_im = (acc_im_q + RND_HALF) >>> FRAC_BITS;
					end
					CLS_MSQ: begin
						emit = 1'b1;
						v_re = ($signed({2'b00, den_q}) + RND_HALF) >>> FRAC_BITS;
					end
					CLS_DIV, CLS_RECIP: begin
						emit = (den_q == '0);
						div0 = (den_q == '0);
					end
					default: emit = 1'b0;
				endcase
			end
			S_DOUT: begin
				emit = 1'b1;
				v_re = neg_re_q ? -$signed({32'b0, qm_re}) : $signed({32'b0, qm_re});
				v_im = neg_im_q ? -$signed({32'b0, qm_im}) : $signed({32'b0, qm_im});
			end
			S_SOUT: begin
				emit = 1'b1;
				v_re = $signed({2'b00, sr_q});
			end
			default: emit = 1'b0;
		endcase
		sr_re = sat32(v_re);
		sr_im = sat32(v_im);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			pv_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= emit;
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					pv_q   <= 1'b0;
					if (pop && !is_simple(head.cls))
						state_q <= S_MUL;
				end
				S_MUL: begin
					pv_q   <= 1'b1;
					step_q <= step_q + 3'd1;
					if (mop.last)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					pv_q    <= 1'b0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					cnt_q <= '0;
					case (item_q.cls)
						CLS_DIV, CLS_RECIP: state_q <= (den_q == '0) ? S_IDLE : S_DIV;
						CLS_MAG:            state_q <= S_SQRT;
						default:            state_q <= S_IDLE;
					endcase
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_div)
						state_q <= S_DOUT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_sqrt)
						state_q <= S_SOUT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pv_q) begin
			case (pdest_q)
				DST_RE_ADD: acc_re_q <= acc_re_q + pext;
				DST_RE_SUB: acc_re_q <= acc_re_q - pext;
				DST_IM_ADD: acc_im_q <= acc_im_q + pext;
				DST_IM_SUB: acc_im_q <= acc_im_q - pext;
				default:    den_q    <= den_q + $unsigned(p_q);
			endcase
		end
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					item_q <= head;
					den_q  <= '0;
					if (head.cls == CLS_RECIP) begin
						// reciprocal dividends are a_re and -a_im scaled by one
						acc_re_q <= sx(head.a_re) <<< FRAC_BITS;
						acc_im_q <= -(sx(head.a_im) <<< FRAC_BITS);
					end else begin
						acc_re_q <= '0;
						acc_im_q <= '0;
					end
				end
			end
			S_MUL: begin
				p_q     <= prod;
				pdest_q <= mop.dest;
			end
			S_FIN: begin
				neg_re_q <= acc_re_q[65];
				neg_im_q <= acc_im_q[65];
				dvd_re_q <= acc_re_q[65] ? 64'(-acc_re_q) : acc_re_q[63:0];
				dvd_im_q <= acc_im_q[65] ? 64'(-acc_im_q) : acc_im_q[63:0];
				rem_re_q <= '0;
				rem_im_q <= '0;
				q_re_q   <= '0;
				q_im_q   <= '0;
				ovf_re_q <= 1'b0;
				ovf_im_q <= 1'b0;
				sn_q     <= den_q;
				sr_q     <= '0;
				sbit_q   <= 64'd1 << 62;
			end
			S_DIV: begin
				dvd_re_q <= {dvd_re_q[62:0], 1'b0};
				dvd_im_q <= {dvd_im_q[62:0], 1'b0};
				rem_re_q <= ge_re ? 64'(t_re - {1'b0, den_q}) : t_re[63:0];
				rem_im_q <= ge_im ? 64'(t_im - {1'b0, den_q}) : t_im[63:0];
				q_re_q   <= {q_re_q[32:0], ge_re};
				q_im_q   <= {q_im_q[32:0], ge_im};
				ovf_re_q <= ovf_re_q | q_re_q[33];
				ovf_im_q <= ovf_im_q | q_im_q[33];
			end
			S_SQRT: begin
				if (st_ge) begin
					sn_q <= sn_q - st_sum;
					sr_q <= (sr_q >> 1) + sbit_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			default: begin
			end
		endcase
		if (emit) begin
			res_re_q <= sr_re.val;
			res_im_q <= sr_im.val;
			if (div0)
				status_q <= ST_DIV0;
			else if (sr_re.sat || sr_im.sat)
				status_q <= ST_SAT;
			else
				status_q <= ST_OK;
		end
	end

	assign done   = done_q;
	assign res_re = res_re_q;
	assign res_im = res_im_q;
	assign status = status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add/sub/mul/div/recip/neg/conj/|a|^2/|a| on signed Q16.16 operands.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; a two-entry
// queue takes new commands while the execution unit works. Each result
// appears for one cycle with done high and must be taken then. In the
// execution unit, add, sub, neg, conj and unused opcodes are done straight
// from the queue head; squared magnitude and multiply use the shared 32x32
// multiplier, one product a cycle; reciprocal and divide use the bit-serial
// divider, one quotient bit a cycle, and skip it when the divisor is zero;
// magnitude uses the bit-serial root, one result bit a cycle.
// Results leave in command order.
module complex_arithmetic_unit_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [3:0]         opcode,
	input  wire logic signed [31:0] a_re,
	input  wire logic signed [31:0] a_im,
	input  wire logic signed [31:0] b_re,
	input  wire logic signed [31:0] b_im,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      res_re,
	output logic signed [31:0]      res_im,
	output logic [1:0]              status
);
	import cau_pkg::*;

	cau_item_t head;
	logic      empty;
	logic      pop;

	cau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.a_re   (a_re),
		.a_im   (a_im),
		.b_re   (b_re),
		.b_im   (b_im),
		.busy   (busy),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	cau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.done   (done),
		.res_re (res_re),
		.res_im (res_im),
		.status (status)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/cau_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [31:0] res_re,
	input wire logic signed [31:0] res_im,
	input wire logic [1:0]         status
);
	import cau_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_DIV0 || status == ST_SAT))
		else $error("undefined status code");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DIV0) |-> (res_re == 32'sd0 && res_im == 32'sd0))
		else $error("divide by zero result not zero");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_SAT) |->
		(res_re == 32'sh7FFF_FFFF || res_re == 32'sh8000_0000 ||
		 res_im == 32'sh7FFF_FFFF || res_im == 32'sh8000_0000))
		else $error("saturated status without a clamped part");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted transaction");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (.*);
`default_nettype wire
